### hw/rtl/sbsh_pkg.sv
// Package with mode codes, constants and helper functions for the string hash block.
package sbsh_pkg;

  // Hash mode codes, as held in the mode register.
  localparam logic [2:0] MODE_ONE    = 3'd0;
  localparam logic [2:0] MODE_FIRST  = 3'd1;
  localparam logic [2:0] MODE_LENGTH = 3'd2;
  localparam logic [2:0] MODE_SUM    = 3'd3;
  localparam logic [2:0] MODE_ROR    = 3'd4;
  localparam logic [2:0] MODE_ROL    = 3'd5;
  localparam logic [2:0] MODE_CRC32  = 3'd6;
  localparam logic [2:0] MODE_CRC32C = 3'd7;

  localparam logic [2:0]  MODE_RESET  = MODE_CRC32;
  localparam logic [31:0] CRC32_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;
  localparam logic [31:0] ALL_ONES    = 32'hFFFFFFFF;

  typedef logic [31:0] hash_t;

  // Start value of a mode: all ones for the CRC modes, zero otherwise.
  function automatic hash_t start_value(input logic [2:0] mode);
    hash_t v;
    v = '0;
    if ((mode == MODE_CRC32) || (mode == MODE_CRC32C)) begin
      v = ALL_ONES;
    end
    return v;
  endfunction

  // One byte of a reflected CRC, processed bit by bit over eight steps.
  function automatic hash_t crc_byte(input hash_t crc, input logic [7:0] b,
                                     input hash_t poly);
    hash_t c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### hw/rtl/selectable_byte_string_hash.sv
// Top level of the selectable byte string hash: input register, state and result register.
//
// Usage: a string is sent one character per item on the in_ channel
// (in_char_byte, in_is_end low), closed by an item with in_is_end high.
// Character items produce no result; each end item produces one item on the
// out_ channel carrying out_hash_value for the string in the mode currently
// held in the mode register, then clears the running state. The mode register
// resets to CRC-32 (mode 6) and is written through cfg_we / cfg_wdata; the
// user must write it only while the block is idle, which it does not enforce.
// An accepted end item waits in the input register until the result register
// is free, then its hash is written there and out_valid rises.
// Throughput: one item per cycle while in_stall is low, set by the combinational
// hash update between the input register and the state / result registers.
// Stall: the result register holds its item while out_stall is high; new
// character items keep flowing, and an end item waits in the input
// register, which then raises in_stall.
// Reset (rst_n low, synchronous) empties both registers, sets the mode to
// CRC-32 and the running hash to its start value.
module selectable_byte_string_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_is_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);

  logic [2:0]      mode_r;
  sbsh_pkg::hash_t hash_r;
  logic            seen_r;
  logic            s1_valid_r;
  logic            s1_valid_nxt;
  logic [7:0]      s1_char_r;
  logic            s1_end_r;
  logic            out_valid_r;
  logic            out_valid_nxt;
  sbsh_pkg::hash_t out_hash_r;
  sbsh_pkg::hash_t hash_nxt;
  sbsh_pkg::hash_t hash_final;
  logic            s1_adv;
  logic            in_take;
  logic            out_take;

  // Handshake: a buffered end item moves only when the result register frees up.
  assign out_take     = out_valid_r && !out_stall;
  assign s1_adv       = s1_valid_r && (!s1_end_r || !out_valid_r || !out_stall);
  assign in_stall     = s1_valid_r && !s1_adv;
  assign in_take      = in_valid && !in_stall;
  assign s1_valid_nxt = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_adv && s1_end_r) ? 1'b1 : (out_take ? 1'b0 : out_valid_r);

  sbsh_update u_update (
    .mode         (mode_r),
    .running_hash (hash_r),
    .seen_char    (seen_r),
    .char_byte    (s1_char_r),
    .hash_nxt     (hash_nxt),
    .hash_final   (hash_final)
  );

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sbsh_pkg::MODE_RESET;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_byte;
      s1_end_r  <= in_is_end;
    end
  end

  // Running hash state, updated as each buffered item is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= sbsh_pkg::start_value(sbsh_pkg::MODE_RESET);
      seen_r <= 1'b0;
    end else if (s1_adv) begin
      if (s1_end_r) begin
        hash_r <= sbsh_pkg::start_value(mode_r);
        seen_r <= 1'b0;
      end else begin
        hash_r <= hash_nxt;
        seen_r <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_end_r) begin
      out_hash_r <= hash_final;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

### hw/rtl/sbsh_update.sv
// Combinational hash update for one character item and the finished hash for an end item.
module sbsh_update (
  input  logic [2:0]           mode,
  input  sbsh_pkg::hash_t      running_hash,
  input  logic                 seen_char,
  input  logic [7:0]           char_byte,
  output sbsh_pkg::hash_t      hash_nxt,
  output sbsh_pkg::hash_t      hash_final
);

  sbsh_pkg::hash_t cur;
  sbsh_pkg::hash_t c_ext;
  sbsh_pkg::hash_t mixed;

  // The running value counts only once a character has been seen.
  assign cur   = seen_char ? running_hash : sbsh_pkg::start_value(mode);
  assign c_ext = {{24{char_byte[7]}}, char_byte};
  assign mixed = cur ^ c_ext;

  // Next running value for a character item under the current mode.
  always_comb begin
    unique case (mode)
      sbsh_pkg::MODE_ONE:    hash_nxt = cur;
      sbsh_pkg::MODE_FIRST:  hash_nxt = seen_char ? cur : c_ext;
      sbsh_pkg::MODE_LENGTH: hash_nxt = cur + 32'd1;
      sbsh_pkg::MODE_SUM:    hash_nxt = cur + c_ext;
      sbsh_pkg::MODE_ROR:    hash_nxt = {mixed[0], mixed[31:1]};
      sbsh_pkg::MODE_ROL:    hash_nxt = {mixed[30:0], mixed[31]};
      sbsh_pkg::MODE_CRC32:  hash_nxt = sbsh_pkg::crc_byte(cur, char_byte,
                                                           sbsh_pkg::CRC32_POLY);
      sbsh_pkg::MODE_CRC32C: hash_nxt = sbsh_pkg::crc_byte(cur, char_byte,
                                                           sbsh_pkg::CRC32C_POLY);
      default:               hash_nxt = cur;
    endcase
  end

  // Finished hash for an end item.
  always_comb begin
    unique case (mode)
      sbsh_pkg::MODE_ONE:   hash_final = 32'd1;
      sbsh_pkg::MODE_CRC32: hash_final = cur ^ sbsh_pkg::ALL_ONES;
      default:              hash_final = cur;
    endcase
  end

endmodule
